// File: rtl/ssu_pkg.sv
// Shared types and constants for the substring search unit.
// No dependencies; imported by every module of the block.
package ssu_pkg;

    localparam int NEEDLE_MAX_DEF = 32;
    localparam int BYTE_W         = 8;
    localparam int POS_W          = 32;
    localparam int REQ_W          = 2;

    typedef enum logic [REQ_W-1:0] {
        REQ_NEEDLE = 2'd0,
        REQ_HAY    = 2'd1,
        REQ_END    = 2'd2
    } t_req;

    // Per-word control from the input stage to the storage modules.
    typedef struct packed {
        logic needle_wr;
        logic hay_wr;
        logic clear;
    } t_step_ctl;

endpackage

// File: rtl/ssu_needle.sv
// Needle storage: bytes held newest first, with length and overflow flag.
// Depends on ssu_pkg.
module ssu_needle #(
    parameter int NEEDLE_MAX = ssu_pkg::NEEDLE_MAX_DEF,
    parameter int LEN_W      = $clog2(NEEDLE_MAX + 1)
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  ssu_pkg::t_step_ctl                      i_ctl,
    input  logic [ssu_pkg::BYTE_W-1:0]              i_byte,
    output logic [NEEDLE_MAX-1:0][ssu_pkg::BYTE_W-1:0] o_needle,
    output logic [LEN_W-1:0]                        o_len,
    output logic                                    o_too_long
);
    import ssu_pkg::*;

    logic [NEEDLE_MAX-1:0][BYTE_W-1:0] r_bytes;
    logic [LEN_W-1:0]                  r_len;
    logic                              r_too_long;
    logic                              w_room;

    assign w_room = (r_len < LEN_W'(NEEDLE_MAX));

    // Entry k holds the byte k places before the last one loaded, so the
    // compare lines up with the haystack window without any index mux.
    always_ff @(posedge i_clk) begin
        if (i_ctl.needle_wr && w_room) begin
            r_bytes[0] <= i_byte;
            for (int k = 1; k < NEEDLE_MAX; k++) begin
                r_bytes[k] <= r_bytes[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len      <= '0;
            r_too_long <= 1'b0;
        end else if (i_ctl.clear) begin
            r_len      <= '0;
            r_too_long <= 1'b0;
        end else if (i_ctl.needle_wr) begin
            if (w_room) begin
                r_len <= r_len + LEN_W'(1);
            end else begin
                r_too_long <= 1'b1;
            end
        end
    end

    assign o_needle   = r_bytes;
    assign o_len      = r_len;
    assign o_too_long = r_too_long;

endmodule

// File: rtl/ssu_matcher.sv
// Haystack window, parallel compare against the needle, position counter
// and first-match latch. Depends on ssu_pkg.
module ssu_matcher #(
    parameter int NEEDLE_MAX = ssu_pkg::NEEDLE_MAX_DEF,
    parameter int LEN_W      = $clog2(NEEDLE_MAX + 1)
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  ssu_pkg::t_step_ctl                      i_ctl,
    input  logic [ssu_pkg::BYTE_W-1:0]              i_byte,
    input  logic [NEEDLE_MAX-1:0][ssu_pkg::BYTE_W-1:0] i_needle,
    input  logic [LEN_W-1:0]                        i_len,
    input  logic                                    i_too_long,
    output logic                                    o_seen,
    output logic [ssu_pkg::POS_W-1:0]               o_first,
    output logic                                    o_pos_ovf
);
    import ssu_pkg::*;

    logic [NEEDLE_MAX-1:0][BYTE_W-1:0] r_win;
    logic [NEEDLE_MAX-1:0][BYTE_W-1:0] n_win;
    logic [POS_W-1:0]                  r_pos;
    logic [POS_W-1:0]                  n_pos;
    logic                              r_seen;
    logic [POS_W-1:0]                  r_first;
    logic                              r_pos_ovf;
    logic [NEEDLE_MAX-1:0]             w_hit;
    logic                              w_sat;
    logic                              w_latch;

    always_comb begin
        n_win[0] = i_byte;
        for (int k = 1; k < NEEDLE_MAX; k++) begin
            n_win[k] = r_win[k-1];
        end
        // Positions at or beyond the needle length do not take part.
        for (int k = 0; k < NEEDLE_MAX; k++) begin
            w_hit[k] = (n_win[k] == i_needle[k]) || (LEN_W'(k) >= i_len);
        end
    end

    assign w_sat   = &r_pos;
    assign n_pos   = r_pos + POS_W'(1);
    assign w_latch = i_ctl.hay_wr && !w_sat && !r_seen && !i_too_long
                   && (i_len != '0) && (n_pos >= POS_W'(i_len)) && (&w_hit);

    // Window bytes older than the position count are never compared, so the
    // window needs no clearing.
    always_ff @(posedge i_clk) begin
        if (i_ctl.hay_wr) begin
            r_win <= n_win;
        end
        if (w_latch) begin
            r_first <= n_pos - POS_W'(i_len);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos     <= '0;
            r_seen    <= 1'b0;
            r_pos_ovf <= 1'b0;
        end else if (i_ctl.clear) begin
            r_pos     <= '0;
            r_seen    <= 1'b0;
            r_pos_ovf <= 1'b0;
        end else if (i_ctl.hay_wr) begin
            if (w_sat) begin
                r_pos_ovf <= 1'b1;
            end else begin
                r_pos <= n_pos;
            end
            if (w_latch) begin
                r_seen <= 1'b1;
            end
        end
    end

    assign o_seen    = r_seen;
    assign o_first   = r_first;
    assign o_pos_ovf = r_pos_ovf;

endmodule

// File: rtl/substring_search_unit.sv
// Substring search unit: streams needle and haystack bytes, reports the
// first needle occurrence on an end word. One word per cycle sustained while no end word stalls.
// The result is registered: an end word sits in the input register until it is processed, and
// then loads the result register.
// An end word, and every word behind it, waits only while the previous result is still
// held. Synchronous active-low reset clears control state; needle and window bytes are not reset.
module substring_search_unit #(
    parameter int NEEDLE_MAX = ssu_pkg::NEEDLE_MAX_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [ssu_pkg::REQ_W-1:0]     i_req_type,
    input  logic [ssu_pkg::BYTE_W-1:0]    i_data_byte,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic                          o_found,
    output logic [ssu_pkg::POS_W-1:0]     o_match_index,
    output logic                          o_needle_too_long,
    output logic                          o_haystack_overflow
);
    import ssu_pkg::*;

    localparam int LEN_W = $clog2(NEEDLE_MAX + 1);

    logic                              r_in_valid;
    logic [REQ_W-1:0]                  r_in_type;
    logic [BYTE_W-1:0]                 r_in_byte;
    logic                              r_out_valid;
    logic                              r_found;
    logic [POS_W-1:0]                  r_index;
    logic                              r_too_long;
    logic                              r_pos_ovf;

    logic                              w_is_end;
    logic                              w_proc;
    t_step_ctl                         w_ctl;
    logic [NEEDLE_MAX-1:0][BYTE_W-1:0] w_needle;
    logic [LEN_W-1:0]                  w_len;
    logic                              w_too_long;
    logic                              w_seen;
    logic [POS_W-1:0]                  w_first;
    logic                              w_pos_ovf;
    logic                              n_found;
    logic [POS_W-1:0]                  n_index;

    assign w_is_end   = (r_in_type == REQ_W'(REQ_END));
    assign w_proc     = r_in_valid && (!w_is_end || !r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || w_proc;

    assign w_ctl.needle_wr = w_proc && (r_in_type == REQ_W'(REQ_NEEDLE));
    assign w_ctl.hay_wr    = w_proc && (r_in_type == REQ_W'(REQ_HAY));
    assign w_ctl.clear     = w_proc && w_is_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_type <= i_req_type;
            r_in_byte <= i_data_byte;
        end
    end

    ssu_needle #(
        .NEEDLE_MAX (NEEDLE_MAX),
        .LEN_W      (LEN_W)
    ) u_needle (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (w_ctl),
        .i_byte     (r_in_byte),
        .o_needle   (w_needle),
        .o_len      (w_len),
        .o_too_long (w_too_long)
    );

    ssu_matcher #(
        .NEEDLE_MAX (NEEDLE_MAX),
        .LEN_W      (LEN_W)
    ) u_matcher (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (w_ctl),
        .i_byte     (r_in_byte),
        .i_needle   (w_needle),
        .i_len      (w_len),
        .i_too_long (w_too_long),
        .o_seen     (w_seen),
        .o_first    (w_first),
        .o_pos_ovf  (w_pos_ovf)
    );

    // An empty needle matches at the start; an oversized one never matches.
    always_comb begin
        priority if (w_too_long) begin
            n_found = 1'b0;
            n_index = '0;
        end else if (w_len == '0) begin
            n_found = 1'b1;
            n_index = '0;
        end else begin
            n_found = w_seen;
            n_index = w_seen ? w_first : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_ctl.clear) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ctl.clear) begin
            r_found    <= n_found;
            r_index    <= n_index;
            r_too_long <= w_too_long;
            r_pos_ovf  <= w_pos_ovf;
        end
    end

    assign o_out_valid         = r_out_valid;
    assign o_found             = r_found;
    assign o_match_index       = r_index;
    assign o_needle_too_long   = r_too_long;
    assign o_haystack_overflow = r_pos_ovf;

    a_found_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_found && o_needle_too_long))
        else $error("found reported together with an oversized needle");

    a_index_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_found) |-> (o_match_index == '0))
        else $error("nonzero match index without a match");

    a_end_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctl.clear |=> o_out_valid)
        else $error("end word did not produce a result");

    a_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctl.clear |=> (w_len == '0) && !w_seen && !w_too_long && !w_pos_ovf)
        else $error("search state not cleared after end word");

endmodule
